FILE: src/bir_pkg.sv
`timescale 1ns / 1ps

package bir_pkg;

  // Default frame store bounds.
  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;

  // Field widths.
  localparam int unsigned COORD_W = 12;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned PIX_W   = 3 * CHAN_W;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned STEP_W  = 24;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned INT_W   = STEP_W + COORD_W - FRAC_W;

  // Shared multiplier and accumulator widths.
  localparam int unsigned MUL_A_W = 2 * (FRAC_W + 1) - 1;
  localparam int unsigned MUL_B_W = FRAC_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned WGT_W   = 2 * FRAC_W + 1;
  localparam int unsigned ACC_W   = 2 * FRAC_W + CHAN_W;

  // Configuration port.
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 4;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEP_X        = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEP_Y        = 2'd3;

  // Item kinds.
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] line;
    logic [CHAN_W-1:0]  red_in;
    logic [CHAN_W-1:0]  green_in;
    logic [CHAN_W-1:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
  } out_item_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic acc_en;
    logic acc_clr;
  } mac_ctrl_t;

endpackage

FILE: src/bir_mac.sv
`timescale 1ns / 1ps

module bir_mac (
  input  logic                         clk_i,
  input  bir_pkg::mac_ctrl_t           ctrl_i,
  input  logic [bir_pkg::MUL_A_W-1:0]  a_i,
  input  logic [bir_pkg::MUL_B_W-1:0]  b_i,
  output logic [bir_pkg::PROD_W-1:0]   prod_o,
  output logic [bir_pkg::ACC_W-1:0]    sum_o
);

  logic [bir_pkg::ACC_W-1:0] acc_q;
  logic [bir_pkg::ACC_W-1:0] acc_d;

  // The single multiplier shared by the position, weight and MAC steps of the sequencer.
  assign prod_o = bir_pkg::PROD_W'(a_i) * bir_pkg::PROD_W'(b_i);

  // Running sum; a cleared step starts a new sum from this product.
  assign sum_o = (ctrl_i.acc_clr ? '0 : acc_q) + prod_o[bir_pkg::ACC_W-1:0];
  assign acc_d = ctrl_i.acc_en ? sum_o : acc_q;

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

FILE: src/bilinear_image_resampler.sv
// A load transfer leaves the sequencer idle, so the next item can follow in the next cycle.
// A request holds off further items until the sequencer returns to idle: one shared
// multiplier gives two position products, four weights overlapped with four frame
// store reads and 12 MACs; DONE waits until the output register can take the result.
// Reset (rst_ni low, asynchronous) clears the sequencer, the output valid and the
// registers to their defaults; the frame store is not cleared and needs no sweep.
`timescale 1ns / 1ps

module bilinear_image_resampler #(
  parameter int unsigned MAX_WIDTH  = bir_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bir_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input items.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bir_pkg::in_item_t           in_data_i,
  // Result items.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bir_pkg::out_item_t          out_data_o,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bir_pkg::APB_AW-1:0]  paddr,
  input  logic [bir_pkg::APB_DW-1:0]  pwdata,
  output logic [bir_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned AW    = CW + RW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned SZ_W  = bir_pkg::COORD_W + 1;
  localparam int unsigned CL_W  = bir_pkg::INT_W + 1;

  localparam logic [SZ_W-1:0] MAX_W_S = SZ_W'(MAX_WIDTH);
  localparam logic [SZ_W-1:0] MAX_H_S = SZ_W'(MAX_HEIGHT);
  localparam logic [bir_pkg::MUL_B_W-1:0] FRAC_ONE = bir_pkg::MUL_B_W'(1 << bir_pkg::FRAC_W);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MULX  = 3'd1;
  localparam logic [2:0] ST_MULY  = 3'd2;
  localparam logic [2:0] ST_FETCH = 3'd3;
  localparam logic [2:0] ST_MAC   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // Color channels in the order they are accumulated.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  logic [2:0] state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] ch_q, ch_d;

  logic [bir_pkg::SIZE_W-1:0] src_width_q, src_height_q;
  logic [bir_pkg::STEP_W-1:0] step_x_q, step_y_q;

  logic [bir_pkg::COORD_W-1:0] col_q, line_q;
  logic [bir_pkg::INT_W-1:0]   ix_q, iy_q;
  logic [bir_pkg::FRAC_W-1:0]  fx_q, fy_q;
  logic [bir_pkg::WGT_W-1:0]   w_q [4];
  logic [bir_pkg::PIX_W-1:0]   pix_q [4];
  logic [bir_pkg::CHAN_W-1:0]  res_q [3];

  logic               out_valid_q, out_valid_d;
  bir_pkg::out_item_t out_data_q;

  logic [bir_pkg::PIX_W-1:0] frame_mem [DEPTH];

  logic in_accept, out_accept, cfg_write, done_load;
  logic load_hit;

  logic [CW-1:0] last_x, x0, x1, fetch_x;
  logic [RW-1:0] last_y, y0, y1, fetch_y;
  logic [CL_W-1:0] ix_inc, iy_inc;
  logic [AW-1:0] rd_addr, wr_addr;

  bir_pkg::mac_ctrl_t          mac_ctrl;
  logic [bir_pkg::MUL_A_W-1:0] mul_a;
  logic [bir_pkg::MUL_B_W-1:0] mul_b;
  logic [bir_pkg::PROD_W-1:0]  prod;
  logic [bir_pkg::ACC_W-1:0]   sum;
  logic [bir_pkg::MUL_B_W-1:0] wx, wy;
  logic [bir_pkg::PIX_W-1:0]   mac_pix;
  logic [bir_pkg::CHAN_W-1:0]  mac_byte;

  // Handshakes.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_accept  = out_valid_q && !out_stall_i;
  assign done_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= bir_pkg::SIZE_W'(256);
      src_height_q <= bir_pkg::SIZE_W'(256);
      step_x_q     <= bir_pkg::STEP_W'(65536);
      step_y_q     <= bir_pkg::STEP_W'(65536);
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        bir_pkg::REG_SOURCE_WIDTH:  src_width_q  <= pwdata[bir_pkg::SIZE_W-1:0];
        bir_pkg::REG_SOURCE_HEIGHT: src_height_q <= pwdata[bir_pkg::SIZE_W-1:0];
        bir_pkg::REG_STEP_X:        step_x_q     <= pwdata[bir_pkg::STEP_W-1:0];
        bir_pkg::REG_STEP_Y:        step_y_q     <= pwdata[bir_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      bir_pkg::REG_SOURCE_WIDTH:  prdata = bir_pkg::APB_DW'(src_width_q);
      bir_pkg::REG_SOURCE_HEIGHT: prdata = bir_pkg::APB_DW'(src_height_q);
      bir_pkg::REG_STEP_X:        prdata = bir_pkg::APB_DW'(step_x_q);
      bir_pkg::REG_STEP_Y:        prdata = bir_pkg::APB_DW'(step_y_q);
      default:                    prdata = '0;
    endcase
  end

  // Last valid column and row, with the size saturated to the store bounds.
  always_comb begin
    if (src_width_q == '0) begin
      last_x = '0;
    end else if (SZ_W'(src_width_q) > MAX_W_S) begin
      last_x = CW'(MAX_W_S - SZ_W'(1));
    end else begin
      last_x = CW'(src_width_q - bir_pkg::SIZE_W'(1));
    end
    if (src_height_q == '0) begin
      last_y = '0;
    end else if (SZ_W'(src_height_q) > MAX_H_S) begin
      last_y = RW'(MAX_H_S - SZ_W'(1));
    end else begin
      last_y = RW'(src_height_q - bir_pkg::SIZE_W'(1));
    end
  end

  // Neighbor coordinates clamped to the last column and row.
  assign ix_inc = CL_W'(ix_q) + CL_W'(1);
  assign iy_inc = CL_W'(iy_q) + CL_W'(1);
  assign x0 = (CL_W'(ix_q) > CL_W'(last_x)) ? last_x : ix_q[CW-1:0];
  assign x1 = (ix_inc > CL_W'(last_x)) ? last_x : ix_inc[CW-1:0];
  assign y0 = (CL_W'(iy_q) > CL_W'(last_y)) ? last_y : iy_q[RW-1:0];
  assign y1 = (iy_inc > CL_W'(last_y)) ? last_y : iy_inc[RW-1:0];

  // Neighbor order: bit 0 of the count picks the right column, bit 1 the lower row.
  assign fetch_x = cnt_q[0] ? x1 : x0;
  assign fetch_y = cnt_q[1] ? y1 : y0;
  assign rd_addr = {fetch_y, fetch_x};
  assign wr_addr = {in_data_i.line[RW-1:0], in_data_i.column[CW-1:0]};
  assign load_hit = in_accept && (in_data_i.kind == bir_pkg::KIND_LOAD)
                    && ({1'b0, in_data_i.column} < MAX_W_S)
                    && ({1'b0, in_data_i.line} < MAX_H_S);

  // Frame store: loads write in the idle state, fetches read afterwards.
  always_ff @(posedge clk_i) begin
    if (load_hit) begin
      frame_mem[wr_addr] <= {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
    end
    if (state_q == ST_FETCH) begin
      pix_q[cnt_q] <= frame_mem[rd_addr];
    end
  end

  // Fractional weights of the current neighbor.
  assign wx = cnt_q[0] ? bir_pkg::MUL_B_W'(fx_q) : (FRAC_ONE - bir_pkg::MUL_B_W'(fx_q));
  assign wy = cnt_q[1] ? bir_pkg::MUL_B_W'(fy_q) : (FRAC_ONE - bir_pkg::MUL_B_W'(fy_q));

  // Channel byte of the current neighbor.
  assign mac_pix = pix_q[cnt_q];
  always_comb begin
    unique case (ch_q)
      CH_RED:   mac_byte = mac_pix[3*bir_pkg::CHAN_W-1:2*bir_pkg::CHAN_W];
      CH_GREEN: mac_byte = mac_pix[2*bir_pkg::CHAN_W-1:bir_pkg::CHAN_W];
      CH_BLUE:  mac_byte = mac_pix[bir_pkg::CHAN_W-1:0];
      default:  mac_byte = '0;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mac_ctrl.acc_en  = (state_q == ST_MAC);
    mac_ctrl.acc_clr = (cnt_q == 2'd0);
    unique case (state_q)
      ST_MULX: begin
        mul_a = bir_pkg::MUL_A_W'(step_x_q);
        mul_b = bir_pkg::MUL_B_W'(col_q);
      end
      ST_MULY: begin
        mul_a = bir_pkg::MUL_A_W'(step_y_q);
        mul_b = bir_pkg::MUL_B_W'(line_q);
      end
      ST_FETCH: begin
        mul_a = bir_pkg::MUL_A_W'(wx);
        mul_b = wy;
      end
      ST_MAC: begin
        mul_a = bir_pkg::MUL_A_W'(w_q[cnt_q]);
        mul_b = bir_pkg::MUL_B_W'(mac_byte);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bir_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod),
    .sum_o  (sum)
  );

  // Datapath registers written by the sequencer.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      col_q  <= in_data_i.column;
      line_q <= in_data_i.line;
    end
    if (state_q == ST_MULX) begin
      ix_q <= prod[bir_pkg::FRAC_W+bir_pkg::INT_W-1:bir_pkg::FRAC_W];
      fx_q <= prod[bir_pkg::FRAC_W-1:0];
    end
    if (state_q == ST_MULY) begin
      iy_q <= prod[bir_pkg::FRAC_W+bir_pkg::INT_W-1:bir_pkg::FRAC_W];
      fy_q <= prod[bir_pkg::FRAC_W-1:0];
    end
    if (state_q == ST_FETCH) begin
      w_q[cnt_q] <= prod[bir_pkg::WGT_W-1:0];
    end
    if ((state_q == ST_MAC) && (cnt_q == 2'd3)) begin
      res_q[ch_q] <= sum[bir_pkg::ACC_W-1:2*bir_pkg::FRAC_W];
    end
    if (done_load) begin
      out_data_q <= {res_q[0], res_q[1], res_q[2]};
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ch_d    = ch_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (in_data_i.kind == bir_pkg::KIND_REQUEST)) begin
          state_d = ST_MULX;
        end
      end
      ST_MULX: state_d = ST_MULY;
      ST_MULY: begin
        state_d = ST_FETCH;
        cnt_d   = 2'd0;
      end
      ST_FETCH: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = ST_MAC;
          ch_d    = CH_RED;
        end
      end
      ST_MAC: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          if (ch_q == CH_BLUE) begin
            state_d = ST_DONE;
          end else begin
            ch_d = ch_q + 2'd1;
          end
        end
      end
      ST_DONE: begin
        if (done_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // The output register holds a result until its transfer completes.
  assign out_valid_d = (out_valid_q && !out_accept) || done_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 2'd0;
      ch_q        <= CH_RED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A request starts the position products in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (in_data_i.kind == bir_pkg::KIND_REQUEST) |=> state_q == ST_MULX)
    else $error("request did not start the sequencer");

  // A load completes in its own cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (in_data_i.kind == bir_pkg::KIND_LOAD) |=> state_q == ST_IDLE)
    else $error("load left the sequencer busy");

  // A result appears only when the sequencer hands one over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result appeared outside the hand-over state");

  // A finished result is never held back from an empty output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && !out_valid_q |=> out_valid_q && (state_q == ST_IDLE))
    else $error("finished result not moved to the output register");

endmodule

FILE: verif/bilinear_image_resampler_tb.sv
`timescale 1ns / 1ps

module bilinear_image_resampler_tb;

  localparam int unsigned MAX_W = bir_pkg::DEF_MAX_WIDTH;
  localparam int unsigned MAX_H = bir_pkg::DEF_MAX_HEIGHT;
  localparam longint unsigned FRAC_ONE = 64'd1 << bir_pkg::FRAC_W;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1350;

  typedef enum logic [1:0] {ROW_CONFIG, ROW_LOAD, ROW_REQUEST} row_op_e;

  typedef struct {
    row_op_e                       op;
    logic [bir_pkg::REG_IDX_W-1:0] reg_idx;
    logic [bir_pkg::APB_DW-1:0]    value;
    bir_pkg::in_item_t             item;
    bit                            typed;
    bir_pkg::out_item_t            want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  bir_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  bir_pkg::out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [bir_pkg::APB_AW-1:0] paddr = '0;
  logic [bir_pkg::APB_DW-1:0] pwdata = '0;
  logic [bir_pkg::APB_DW-1:0] prdata;
  logic pready;

  // Shadow copy of the register file and the frame store.
  logic [bir_pkg::SIZE_W-1:0] cfg_src_width = 9'd256;
  logic [bir_pkg::SIZE_W-1:0] cfg_src_height = 9'd256;
  logic [bir_pkg::STEP_W-1:0] cfg_step_x = 24'h010000;
  logic [bir_pkg::STEP_W-1:0] cfg_step_y = 24'h010000;
  logic [bir_pkg::PIX_W-1:0] shadow_frame [0:MAX_W*MAX_H-1];
  bit pixel_loaded [0:MAX_W*MAX_H-1];

  bir_pkg::out_item_t expected_pixels [$];
  bir_pkg::out_item_t oldest_pixel;
  dir_row_t dir_rows [$];

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int items_sent = 0;
  int config_count = 0;
  int cycle_count = 0;

  bilinear_image_resampler uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk_i = ~clk_i;

  // Saturate a size register to the range of the frame store.
  function automatic int unsigned eff_size(input logic [bir_pkg::SIZE_W-1:0] v,
                                           input int unsigned max);
    if (v == 0) return 1;
    if (32'(v) > max) return max;
    return 32'(v);
  endfunction

  // Source neighbors and fractions of a destination pixel, clamped to the frame.
  function automatic void neighbors(input logic [bir_pkg::COORD_W-1:0] col,
                                    input logic [bir_pkg::COORD_W-1:0] row,
                                    output int unsigned x0, output int unsigned x1,
                                    output int unsigned y0, output int unsigned y1,
                                    output longint unsigned fx, output longint unsigned fy);
    longint unsigned last_x, last_y, sx, sy, cc, rr, ix, iy;
    last_x = 64'(eff_size(cfg_src_width, MAX_W) - 1);
    last_y = 64'(eff_size(cfg_src_height, MAX_H) - 1);
    sx = 64'(cfg_step_x);
    sy = 64'(cfg_step_y);
    cc = 64'(col);
    rr = 64'(row);
    ix = (sx * cc) >> bir_pkg::FRAC_W;
    iy = (sy * rr) >> bir_pkg::FRAC_W;
    fx = (sx * cc) & (FRAC_ONE - 1);
    fy = (sy * rr) & (FRAC_ONE - 1);
    x0 = 32'((ix > last_x) ? last_x : ix);
    x1 = 32'((ix + 1 > last_x) ? last_x : ix + 1);
    y0 = 32'((iy > last_y) ? last_y : iy);
    y1 = 32'((iy + 1 > last_y) ? last_y : iy + 1);
  endfunction

  // Weighted sum of the four neighbors, truncated toward zero.
  function automatic bir_pkg::out_item_t interpolate(input logic [bir_pkg::COORD_W-1:0] col,
                                                     input logic [bir_pkg::COORD_W-1:0] row);
    int unsigned x0, x1, y0, y1;
    longint unsigned fx, fy, w00, w10, w01, w11, sum;
    logic [bir_pkg::PIX_W-1:0] p00, p10, p01, p11;
    logic [bir_pkg::CHAN_W-1:0] chan [3];
    bir_pkg::out_item_t res;
    int sh;
    neighbors(col, row, x0, x1, y0, y1, fx, fy);
    p00 = shadow_frame[y0 * MAX_W + x0];
    p10 = shadow_frame[y0 * MAX_W + x1];
    p01 = shadow_frame[y1 * MAX_W + x0];
    p11 = shadow_frame[y1 * MAX_W + x1];
    w00 = (FRAC_ONE - fx) * (FRAC_ONE - fy);
    w10 = fx * (FRAC_ONE - fy);
    w01 = (FRAC_ONE - fx) * fy;
    w11 = fx * fy;
    for (int ch = 0; ch < 3; ch++) begin
      sh = 16 - 8 * ch;
      sum = 64'(p00[sh +: bir_pkg::CHAN_W]) * w00 + 64'(p10[sh +: bir_pkg::CHAN_W]) * w10
          + 64'(p01[sh +: bir_pkg::CHAN_W]) * w01 + 64'(p11[sh +: bir_pkg::CHAN_W]) * w11;
      chan[ch] = bir_pkg::CHAN_W'(sum >> (2 * bir_pkg::FRAC_W));
    end
    res.red_out = chan[0];
    res.green_out = chan[1];
    res.blue_out = chan[2];
    return res;
  endfunction

  // True when every frame store entry that a request reads has been loaded.
  function automatic bit pixel_ready(input logic [bir_pkg::COORD_W-1:0] col,
                                     input logic [bir_pkg::COORD_W-1:0] row);
    int unsigned x0, x1, y0, y1;
    longint unsigned fx, fy;
    neighbors(col, row, x0, x1, y0, y1, fx, fy);
    return pixel_loaded[y0 * MAX_W + x0] && pixel_loaded[y0 * MAX_W + x1]
        && pixel_loaded[y1 * MAX_W + x0] && pixel_loaded[y1 * MAX_W + x1];
  endfunction

  function automatic dir_row_t row_cfg(input logic [bir_pkg::REG_IDX_W-1:0] idx,
                                       input logic [bir_pkg::APB_DW-1:0] val);
    row_cfg = '{op: ROW_CONFIG, reg_idx: idx, value: val, item: '0, typed: 1'b0, want: '0};
  endfunction

  function automatic dir_row_t row_load(input int col, input int row,
                                        input logic [bir_pkg::PIX_W-1:0] px);
    row_load = '{op: ROW_LOAD, reg_idx: '0, value: '0,
                 item: {bir_pkg::KIND_LOAD, col[bir_pkg::COORD_W-1:0],
                        row[bir_pkg::COORD_W-1:0], px},
                 typed: 1'b0, want: '0};
  endfunction

  function automatic dir_row_t row_req(input int col, input int row, input bit typed,
                                       input logic [bir_pkg::PIX_W-1:0] px);
    row_req = '{op: ROW_REQUEST, reg_idx: '0, value: '0,
                item: {bir_pkg::KIND_REQUEST, col[bir_pkg::COORD_W-1:0],
                       row[bir_pkg::COORD_W-1:0], {bir_pkg::PIX_W{1'b0}}},
                typed: typed, want: bir_pkg::out_item_t'(px)};
  endfunction

  function automatic logic [bir_pkg::CHAN_W-1:0] rand_chan();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return bir_pkg::CHAN_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [bir_pkg::APB_DW-1:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 8);
    if (r < 75) return $urandom_range(9, 20);
    if (r < 80) return 0;
    if (r < 85) return $urandom_range(257, 511);
    return 256;
  endfunction

  function automatic logic [bir_pkg::APB_DW-1:0] rand_step(input int eff, input int dst);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return ((eff - 1) << bir_pkg::FRAC_W) / dst;
    if (r < 75) return $urandom_range(0, 24'hFFFFFF);
    if (r < 85) return 0;
    if (r < 95) return 32'h00FFFFFF;
    return 32'h00010000;
  endfunction

  function automatic logic [bir_pkg::COORD_W-1:0] rand_coord(input int dst);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return bir_pkg::COORD_W'($urandom_range(0, 15));
    if (r < 75) return bir_pkg::COORD_W'($urandom_range(0, dst));
    return bir_pkg::COORD_W'($urandom_range(0, 4095));
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Register write through the configuration port; the shadow copy follows it.
  task automatic cfg_write(input logic [bir_pkg::REG_IDX_W-1:0] idx,
                           input logic [bir_pkg::APB_DW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      bir_pkg::REG_SOURCE_WIDTH:  cfg_src_width = val[bir_pkg::SIZE_W-1:0];
      bir_pkg::REG_SOURCE_HEIGHT: cfg_src_height = val[bir_pkg::SIZE_W-1:0];
      bir_pkg::REG_STEP_X:        cfg_step_x = val[bir_pkg::STEP_W-1:0];
      bir_pkg::REG_STEP_Y:        cfg_step_y = val[bir_pkg::STEP_W-1:0];
      default: ;
    endcase
    config_count++;
    @(posedge clk_i);
  endtask

  // Wait until every expected pixel has come and the block has settled.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One input transfer; the prediction is made at the edge that accepts it.
  task automatic send_item(input bir_pkg::in_item_t it, input bit typed,
                           input bir_pkg::out_item_t want);
    int gap;
    int unsigned idx;
    gap = 0;
    while ($urandom_range(0, 99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (it.kind == bir_pkg::KIND_LOAD) begin
      if (it.column < MAX_W && it.line < MAX_H) begin
        idx = 32'(it.line) * MAX_W + 32'(it.column);
        shadow_frame[idx] = {it.red_in, it.green_in, it.blue_in};
        pixel_loaded[idx] = 1'b1;
      end
    end else begin
      expected_pixels.push_back(typed ? want : interpolate(it.column, it.line));
    end
    items_sent++;
  endtask

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  // Compare each result transfer with the oldest expected pixel.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        flag_mismatch($sformatf("result %h with nothing expected", out_data_o));
      end else begin
        oldest_pixel = expected_pixels.pop_front();
        if (out_data_o.red_out !== oldest_pixel.red_out)
          flag_mismatch($sformatf("red %h, expected %h", out_data_o.red_out,
                                  oldest_pixel.red_out));
        if (out_data_o.green_out !== oldest_pixel.green_out)
          flag_mismatch($sformatf("green %h, expected %h", out_data_o.green_out,
                                  oldest_pixel.green_out));
        if (out_data_o.blue_out !== oldest_pixel.blue_out)
          flag_mismatch($sformatf("blue %h, expected %h", out_data_o.blue_out,
                                  oldest_pixel.blue_out));
        results_checked++;
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("bilinear_image_resampler regression: fail");
    $finish;
  end

  initial begin
    int phase, n, tries, effw, effh, dstw, dsth, xs, ys, r;
    bir_pkg::in_item_t it;

    // Directed rows: reset values first, then the size and edge cases.
    dir_rows.push_back(row_load(0, 0, 24'h123456));
    dir_rows.push_back(row_load(1, 0, 24'hFF00FF));
    dir_rows.push_back(row_load(0, 1, 24'h00FF00));
    dir_rows.push_back(row_load(1, 1, 24'h807F01));
    dir_rows.push_back(row_req(0, 0, 1'b1, 24'h123456));
    dir_rows.push_back(row_load(255, 255, 24'hFFFFFF));
    dir_rows.push_back(row_req(255, 255, 1'b1, 24'hFFFFFF));
    dir_rows.push_back(row_req(4095, 4095, 1'b1, 24'hFFFFFF));
    // Loads outside the store are dropped.
    dir_rows.push_back(row_load(4095, 255, 24'h000000));
    dir_rows.push_back(row_load(255, 4095, 24'h000000));
    dir_rows.push_back(row_load(4095, 4095, 24'h000000));
    dir_rows.push_back(row_req(4095, 4095, 1'b1, 24'hFFFFFF));
    dir_rows.push_back(row_load(255, 255, 24'h000000));
    dir_rows.push_back(row_req(255, 255, 1'b1, 24'h000000));
    // A zero size saturates to one pixel, so only the corner is read.
    dir_rows.push_back(row_cfg(bir_pkg::REG_SOURCE_WIDTH, 32'd0));
    dir_rows.push_back(row_cfg(bir_pkg::REG_SOURCE_HEIGHT, 32'd0));
    dir_rows.push_back(row_cfg(bir_pkg::REG_STEP_X, 32'h00008000));
    dir_rows.push_back(row_cfg(bir_pkg::REG_STEP_Y, 32'h00008000));
    dir_rows.push_back(row_req(3, 5, 1'b1, 24'h123456));
    // Oversized frame and the largest step clamp to the last pixel.
    dir_rows.push_back(row_cfg(bir_pkg::REG_SOURCE_WIDTH, 32'd511));
    dir_rows.push_back(row_cfg(bir_pkg::REG_SOURCE_HEIGHT, 32'd511));
    dir_rows.push_back(row_cfg(bir_pkg::REG_STEP_X, 32'h00FFFFFF));
    dir_rows.push_back(row_cfg(bir_pkg::REG_STEP_Y, 32'h00FFFFFF));
    dir_rows.push_back(row_req(4095, 4095, 1'b1, 24'h000000));
    // Half-pixel steps on a 2x2 frame blend up to four neighbors.
    dir_rows.push_back(row_cfg(bir_pkg::REG_SOURCE_WIDTH, 32'd2));
    dir_rows.push_back(row_cfg(bir_pkg::REG_SOURCE_HEIGHT, 32'd2));
    dir_rows.push_back(row_cfg(bir_pkg::REG_STEP_X, 32'h00008000));
    dir_rows.push_back(row_cfg(bir_pkg::REG_STEP_Y, 32'h00008000));
    dir_rows.push_back(row_req(1, 1, 1'b0, '0));
    dir_rows.push_back(row_req(2, 3, 1'b0, '0));
    dir_rows.push_back(row_req(1, 0, 1'b0, '0));
    // Loads beyond the source size are still stored.
    dir_rows.push_back(row_load(5, 5, 24'hA5C3E7));
    dir_rows.push_back(row_load(6, 5, 24'h0F1E2D));
    dir_rows.push_back(row_load(5, 6, 24'h3C4B5A));
    dir_rows.push_back(row_load(6, 6, 24'h697887));
    dir_rows.push_back(row_cfg(bir_pkg::REG_SOURCE_WIDTH, 32'd8));
    dir_rows.push_back(row_cfg(bir_pkg::REG_SOURCE_HEIGHT, 32'd8));
    dir_rows.push_back(row_cfg(bir_pkg::REG_STEP_X, 32'h00010000));
    dir_rows.push_back(row_cfg(bir_pkg::REG_STEP_Y, 32'h00010000));
    dir_rows.push_back(row_req(5, 5, 1'b1, 24'hA5C3E7));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; items go without idle gaps, register writes wait for idle.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_CONFIG) begin
        wait_idle();
        cfg_write(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases, each with its own frame size, steps and idling pattern.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      case (phase % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 46; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 46; end
        default: begin snd_idle_pct = 15; rcv_stall_pct = 15; end
      endcase
      cfg_write(bir_pkg::REG_SOURCE_WIDTH, rand_size());
      cfg_write(bir_pkg::REG_SOURCE_HEIGHT, rand_size());
      effw = eff_size(cfg_src_width, MAX_W);
      effh = eff_size(cfg_src_height, MAX_H);
      dstw = $urandom_range(1, 2 * effw + 2);
      dsth = $urandom_range(1, 2 * effh + 2);
      cfg_write(bir_pkg::REG_STEP_X, rand_step(effw, dstw));
      cfg_write(bir_pkg::REG_STEP_Y, rand_step(effh, dsth));

      // Fill the source frame, or a corner of it when the frame is large.
      xs = effw;
      ys = effh;
      if (effw * effh > 120) begin
        xs = (effw < 16) ? effw : 16;
        ys = (effh < 6) ? effh : 6;
      end
      for (int y = 0; y < ys; y++) begin
        for (int x = 0; x < xs; x++) begin
          it = {bir_pkg::KIND_LOAD, x[bir_pkg::COORD_W-1:0], y[bir_pkg::COORD_W-1:0],
                rand_chan(), rand_chan(), rand_chan()};
          send_item(it, 1'b0, '0);
        end
      end

      // Mostly requests, with reloads and dropped loads mixed in.
      for (n = 0; n < 60 && items_sent < ITEM_TARGET; n++) begin
        if (n == 30 && phase % 4 == 1) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (expected_pixels.size() != 0) @(posedge clk_i);
        end
        r = $urandom_range(0, 99);
        it.kind = (r < 70) ? bir_pkg::KIND_REQUEST : bir_pkg::KIND_LOAD;
        it.red_in = rand_chan();
        it.green_in = rand_chan();
        it.blue_in = rand_chan();
        if (r < 70) begin
          tries = 0;
          do begin
            it.column = rand_coord(dstw);
            it.line = rand_coord(dsth);
            tries++;
          end while (!pixel_ready(it.column, it.line) && tries < 20);
          if (!pixel_ready(it.column, it.line)) begin
            it.column = '0;
            it.line = '0;
          end
        end else if (r < 82) begin
          it.column = bir_pkg::COORD_W'($urandom_range(0, xs - 1));
          it.line = bir_pkg::COORD_W'($urandom_range(0, ys - 1));
        end else if (r < 88) begin
          it.column = bir_pkg::COORD_W'($urandom_range(0, MAX_W - 1));
          it.line = bir_pkg::COORD_W'($urandom_range(0, MAX_H - 1));
        end else if (r < 94) begin
          it.column = bir_pkg::COORD_W'($urandom_range(MAX_W, 4095));
          it.line = bir_pkg::COORD_W'($urandom_range(0, 4095));
        end else begin
          it.column = bir_pkg::COORD_W'($urandom_range(0, 4095));
          it.line = bir_pkg::COORD_W'($urandom_range(MAX_H, 4095));
        end
        send_item(it, 1'b0, '0);
      end
      phase++;
    end

    // Drain and let the pipeline settle.
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_pixels.size() != 0)
      flag_mismatch($sformatf("%0d expected pixels never arrived", expected_pixels.size()));

    $display("Sent %0d input transfers over %0d random frame settings, %0d register writes.",
             items_sent, phase, config_count);
    $display("Checked %0d interpolated pixels, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("bilinear_image_resampler regression: pass");
    end else begin
      $display("bilinear_image_resampler regression: fail");
    end
    $finish;
  end

endmodule
